[rtl/spuv_pkg.sv]
// Shared types, constants and step functions for the spherical UV mapper.
// Used by spuv_sqrt, spuv_cordic and spherical_uv_map_top; no dependencies.
package spuv_pkg;

    localparam int COORD_W   = 16;
    localparam int ANGLE_W   = 16;
    localparam int RAD_W     = 48;   // radicand width of the root pipeline
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 1;
    localparam int SQ_STAGES = 6;
    localparam int SQ_PER    = ROOT_W / SQ_STAGES;
    localparam int CD_STEPS  = 32;
    localparam int CD_STAGES = 8;
    localparam int CD_PER    = CD_STEPS / CD_STAGES;
    localparam int CV_W      = 27;   // CORDIC vector width
    localparam int CZ_W      = 33;   // angle accumulator, pi = 2^31
    localparam int PIPE_LEN  = 2 + SQ_STAGES + CD_STAGES;

    // register indexes
    localparam logic [0:0] REG_AXIS_MODE = 1'b0;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_state_t;

    typedef struct packed {
        logic signed [CV_W-1:0] xv;
        logic signed [CV_W-1:0] yv;
        logic signed [CZ_W-1:0] z;
    } cd_state_t;

    localparam logic [29:0] ATAN_STEP [0:CD_STEPS-1] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001,
        30'h00000001, 30'h00000000
    };

    // one digit of a restoring square root, two radicand bits at a time
    function automatic sq_state_t sqrt_step(sq_state_t s);
        sq_state_t   n;
        logic [26:0] acc;
        logic [26:0] trial;
        acc   = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = {1'b0, s.root, 2'b01};
        n.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (acc >= trial) begin
            n.rem  = REM_W'(acc - trial);
            n.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            n.rem  = acc[REM_W-1:0];
            n.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return n;
    endfunction

    // one vectoring rotation; shifts floor toward minus infinity
    function automatic cd_state_t cordic_step(cd_state_t s, logic [4:0] i);
        cd_state_t              n;
        logic signed [CV_W-1:0] dx;
        logic signed [CV_W-1:0] dy;
        logic signed [CZ_W-1:0] a;
        dx = s.yv >>> i;
        dy = s.xv >>> i;
        a  = $signed({3'b000, ATAN_STEP[i]});
        if (!s.yv[CV_W-1]) begin
            n.xv = s.xv + dx;
            n.yv = s.yv - dy;
            n.z  = s.z + a;
        end else begin
            n.xv = s.xv - dx;
            n.yv = s.yv + dy;
            n.z  = s.z - a;
        end
        return n;
    endfunction

    // Q0.31 angle to Q0.16: clamp below zero, round half up, saturate
    function automatic logic [ANGLE_W-1:0] angle_out(logic signed [CZ_W:0] q);
        logic [CZ_W:0] r;
        r = ($unsigned(q) + (CZ_W+1)'(1 << (30 - ANGLE_W))) >> (31 - ANGLE_W);
        if (q[CZ_W]) begin
            return '0;
        end else if (|r[CZ_W:ANGLE_W]) begin
            return '1;
        end else begin
            return r[ANGLE_W-1:0];
        end
    endfunction

endpackage

[rtl/spuv_sqrt.sv]
// Pipelined restoring square root: 48-bit radicand, 24-bit floor root and 25-bit remainder.
// Depends on spuv_pkg for the step function and stage counts.
module spuv_sqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [spuv_pkg::RAD_W-1:0]    rad_in,
    output logic [spuv_pkg::ROOT_W-1:0]   root_out,
    output logic [spuv_pkg::REM_W-1:0]    rem_out
);

    spuv_pkg::sq_state_t st_reg  [1:spuv_pkg::SQ_STAGES];
    spuv_pkg::sq_state_t st_next [1:spuv_pkg::SQ_STAGES];
    spuv_pkg::sq_state_t st_in   [1:spuv_pkg::SQ_STAGES];

    assign st_in[1] = '{rad: rad_in, rem: '0, root: '0};

    for (genvar k = 1; k <= spuv_pkg::SQ_STAGES; k++) begin : g_stage
        if (k > 1) begin : g_link
            assign st_in[k] = st_reg[k-1];
        end

        always_comb begin
            spuv_pkg::sq_state_t s;
            s = st_in[k];
            for (int j = 0; j < spuv_pkg::SQ_PER; j++) begin
                s = spuv_pkg::sqrt_step(s);
            end
            st_next[k] = s;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign root_out = st_reg[spuv_pkg::SQ_STAGES].root;
    assign rem_out  = st_reg[spuv_pkg::SQ_STAGES].rem;

endmodule

[rtl/spuv_cordic.sv]
// Pipelined vectoring CORDIC: atan2(p, q) with pi = 2^31, four rotations per stage.
// Depends on spuv_pkg for the arctangent table and step function.
module spuv_cordic (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic [spuv_pkg::ROOT_W-1:0]          q_in,
    input  logic signed [spuv_pkg::COORD_W-1:0]  p_in,
    output logic signed [spuv_pkg::CZ_W-1:0]     angle_out
);

    localparam int PAD = spuv_pkg::CV_W - spuv_pkg::COORD_W - 8;

    spuv_pkg::cd_state_t st_reg  [1:spuv_pkg::CD_STAGES];
    spuv_pkg::cd_state_t st_next [1:spuv_pkg::CD_STAGES];
    spuv_pkg::cd_state_t st_in   [1:spuv_pkg::CD_STAGES];

    // start vector (q, p * 256)
    assign st_in[1] = '{
        xv: $signed({{(spuv_pkg::CV_W-spuv_pkg::ROOT_W){1'b0}}, q_in}),
        yv: $signed({{PAD{p_in[spuv_pkg::COORD_W-1]}}, p_in, 8'h00}),
        z:  '0
    };

    for (genvar k = 1; k <= spuv_pkg::CD_STAGES; k++) begin : g_stage
        if (k > 1) begin : g_link
            assign st_in[k] = st_reg[k-1];
        end

        always_comb begin
            spuv_pkg::cd_state_t s;
            s = st_in[k];
            for (int j = 0; j < spuv_pkg::CD_PER; j++) begin
                s = spuv_pkg::cordic_step(s, 5'((k - 1) * spuv_pkg::CD_PER + j));
            end
            st_next[k] = s;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign angle_out = st_reg[spuv_pkg::CD_STAGES].z;

endmodule

[rtl/spherical_uv_map_top.sv]
// Pipeline: input transfer to result on m_tdata through squares, sums,
// 6 root stages, 8 CORDIC stages and the output register, held under stall.
// Throughput: one vertex per cycle; the whole pipeline advances together and
// holds while the output register is full and m_tready is low.
// Reset (aresetn low, synchronous) empties the pipeline and clears axis_mode.
// Depends on spuv_pkg, spuv_sqrt and spuv_cordic.
module spherical_uv_map_top (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input vertices
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // coord_x, coord_y, coord_z
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // tex_u, tex_v, radius
);

    localparam int CW = spuv_pkg::COORD_W;

    typedef struct packed {
        logic                 zero;
        logic signed [CW-1:0] pu;
        logic signed [CW-1:0] pv;
    } side_t;

    typedef struct packed {
        logic          zero;
        logic [CW-1:0] radius;
    } rad_t;

    logic                        axis_mode_reg;
    logic                        adv;
    logic [spuv_pkg::PIPE_LEN-1:0] valid_reg;
    logic                        m_tvalid_reg;
    logic [47:0]                 m_tdata_reg;
    logic [47:0]                 m_tdata_next;

    logic signed [CW-1:0] cx, cy, cz;
    logic signed [CW-1:0] x1_reg, y1_reg, z1_reg;
    logic [30:0]          sx_reg, sy_reg, sz_reg;
    logic [31:0]          tot_reg, ou_reg, ov_reg;
    side_t                side2_reg;
    side_t                side_dly_reg [1:spuv_pkg::SQ_STAGES];
    rad_t                 rad_dly_reg  [1:spuv_pkg::CD_STAGES];
    rad_t                 rad_next;

    logic [spuv_pkg::ROOT_W-1:0] r_root, u_root, v_root;
    logic [spuv_pkg::REM_W-1:0]  r_rem, u_rem, v_rem;
    logic signed [spuv_pkg::CZ_W-1:0] zu, zv;
    logic signed [spuv_pkg::CZ_W:0]   u_q, v_q;

    function automatic logic [spuv_pkg::REM_W-1:0] REM_W_ROOT(
        logic [spuv_pkg::ROOT_W-1:0] v);
        return {1'b0, v};
    endfunction

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_mode_reg <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == spuv_pkg::REG_AXIS_MODE) begin
            axis_mode_reg <= pwdata[0];
        end
    end
    assign prdata = (paddr[2] == spuv_pkg::REG_AXIS_MODE) ? {31'b0, axis_mode_reg} : 32'b0;

    // the pipeline moves whenever the output register can take a transfer
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg    <= {valid_reg[spuv_pkg::PIPE_LEN-2:0], s_tvalid};
            m_tvalid_reg <= valid_reg[spuv_pkg::PIPE_LEN-1];
        end
    end

    assign cx = $signed(s_tdata[15:0]);
    assign cy = $signed(s_tdata[31:16]);
    assign cz = $signed(s_tdata[47:32]);

    // stage 1: squares, 32-bit signed products kept as 31-bit unsigned
    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg <= cx;
            y1_reg <= cy;
            z1_reg <= cz;
            sx_reg <= 31'($unsigned(32'(cx) * 32'(cx)));
            sy_reg <= 31'($unsigned(32'(cy) * 32'(cy)));
            sz_reg <= 31'($unsigned(32'(cz) * 32'(cz)));
        end
    end

    // stage 2: sums and axis select
    always_ff @(posedge aclk) begin
        if (adv) begin
            tot_reg <= 32'(sx_reg) + 32'(sy_reg) + 32'(sz_reg);
            ou_reg  <= 32'(sy_reg) + 32'(sz_reg);
            ov_reg  <= axis_mode_reg ? 32'(sx_reg) + 32'(sy_reg)
                                     : 32'(sx_reg) + 32'(sz_reg);
            side2_reg.zero <= (sx_reg == '0) && (sy_reg == '0) && (sz_reg == '0);
            side2_reg.pu   <= x1_reg;
            side2_reg.pv   <= axis_mode_reg ? z1_reg : y1_reg;
        end
    end

    spuv_sqrt u_sqrt_r (
        .aclk     (aclk),
        .en       (adv),
        .rad_in   ({16'h0000, tot_reg}),
        .root_out (r_root),
        .rem_out  (r_rem)
    );

    spuv_sqrt u_sqrt_u (
        .aclk     (aclk),
        .en       (adv),
        .rad_in   ({ou_reg, 16'h0000}),
        .root_out (u_root),
        .rem_out  (u_rem)
    );

    spuv_sqrt u_sqrt_v (
        .aclk     (aclk),
        .en       (adv),
        .rad_in   ({ov_reg, 16'h0000}),
        .root_out (v_root),
        .rem_out  (v_rem)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_dly_reg[1] <= side2_reg;
            for (int k = 2; k <= spuv_pkg::SQ_STAGES; k++) begin
                side_dly_reg[k] <= side_dly_reg[k-1];
            end
        end
    end

    // radius rounds to nearest: bump when remainder exceeds root
    always_comb begin
        rad_next.zero   = side_dly_reg[spuv_pkg::SQ_STAGES].zero;
        rad_next.radius = r_root[CW-1:0] + CW'(r_rem > REM_W_ROOT(r_root));
    end

    spuv_cordic u_cordic_u (
        .aclk      (aclk),
        .en        (adv),
        .q_in      (u_root),
        .p_in      (side_dly_reg[spuv_pkg::SQ_STAGES].pu),
        .angle_out (zu)
    );

    spuv_cordic u_cordic_v (
        .aclk      (aclk),
        .en        (adv),
        .q_in      (v_root),
        .p_in      (side_dly_reg[spuv_pkg::SQ_STAGES].pv),
        .angle_out (zv)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            rad_dly_reg[1] <= rad_next;
            for (int k = 2; k <= spuv_pkg::CD_STAGES; k++) begin
                rad_dly_reg[k] <= rad_dly_reg[k-1];
            end
        end
    end

    // u = z_u + pi/2, v = pi/2 - z_v, in Q0.31
    assign u_q = $signed({zu[spuv_pkg::CZ_W-1], zu}) + (spuv_pkg::CZ_W+1)'(34'sh40000000);
    assign v_q = (spuv_pkg::CZ_W+1)'(34'sh40000000) - $signed({zv[spuv_pkg::CZ_W-1], zv});

    always_comb begin
        if (rad_dly_reg[spuv_pkg::CD_STAGES].zero) begin
            m_tdata_next = '0;
        end else begin
            m_tdata_next = {rad_dly_reg[spuv_pkg::CD_STAGES].radius,
                            spuv_pkg::angle_out(v_q),
                            spuv_pkg::angle_out(u_q)};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a zero radius only comes from the zero vertex, which maps to u = v = 0
    a_zero_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[47:32] == 16'h0000 |-> m_tdata_reg[31:0] == 32'h0)
        else $error("zero radius with nonzero texture coordinates");

    a_hold_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(valid_reg) && $stable(m_tdata_reg))
        else $error("pipeline moved during stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid_reg && valid_reg == '0)
        else $error("pipeline not empty after reset");

endmodule
